### design/qtnco_pkg.sv
// ----------------------------------------------------------------------------
// qtnco_pkg
// shared constants, pipeline tag types and the sine table builder
// ----------------------------------------------------------------------------
package qtnco_pkg;

    localparam int STEP_BITS            = 32;
    localparam int WORD_BITS            = 16;
    localparam int PHASE_BITS_DEF       = 32;
    localparam int TABLE_ADDR_BITS_DEF  = 10;
    localparam int IN_TDATA_BITS        = 8;
    localparam int OUT_TDATA_BITS       = 2 * WORD_BITS;

    localparam logic [WORD_BITS-1:0] AMPLITUDE = 16'd2000;
    localparam logic [WORD_BITS-1:0] I_MARK    = 16'ha000;
    localparam logic [WORD_BITS-1:0] Q_MARK    = 16'h5000;

    // pi/2 in Q62
    localparam logic [63:0] PI_HALF_Q62 = 64'd7244019458077122842;

    localparam int TAYLOR_TERMS = 12;

    // (2n) * (2n + 1) for term n of the series, n = 1 in the lowest slot
    localparam logic [TAYLOR_TERMS:1][63:0] TAYLOR_DIV = {
        64'd600, 64'd506, 64'd420, 64'd342, 64'd272, 64'd210,
        64'd156, 64'd110, 64'd72,  64'd42,  64'd20,  64'd6
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // tag that travels beside the phase word
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    // tag that travels beside the table words
    typedef struct packed {
        logic  valid;
        logic  last;
        t_quad quad;
    } t_rom_tag;

    // (a * b) >> 62, kept to 64 bits
    function automatic logic [63:0] mul_shr62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // table entry k of a quarter wave with 2^addr_bits steps, elaboration only
    function automatic logic [WORD_BITS-1:0] sin_entry(input int k, input int addr_bits);
        logic [63:0] step_q;
        logic [63:0] step_r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] kk;
        logic [63:0] prod;
        step_q = PI_HALF_Q62 >> addr_bits;
        step_r = PI_HALF_Q62 & ((64'd1 << addr_bits) - 64'd1);
        kk     = 64'(k);
        x      = step_q * kk + ((step_r * kk) >> addr_bits);
        x2     = mul_shr62(x, x);
        term   = x;
        sum    = x;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = mul_shr62(term, x2) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        prod = mul_shr62(sum, {48'd0, AMPLITUDE});
        if (k == 0) begin
            return '0;
        end else if (k == (1 << addr_bits)) begin
            return AMPLITUDE;
        end else begin
            return prod[WORD_BITS-1:0];
        end
    endfunction

endpackage

### design/qtnco_phase.sv
// ----------------------------------------------------------------------------
// qtnco_phase
// phase step register and phase accumulator, first pipeline stage
// ----------------------------------------------------------------------------
module qtnco_phase #(
    parameter int PHASE_BITS = qtnco_pkg::PHASE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wvalid,
    input  logic [qtnco_pkg::STEP_BITS-1:0] i_cfg_wdata,
    input  logic                           i_accept,
    input  logic                           i_last,
    input  logic                           i_adv,
    output logic [PHASE_BITS-1:0]          o_phase,
    output qtnco_pkg::t_tag                o_tag
);
    import qtnco_pkg::*;

    logic [STEP_BITS-1:0]  r_step;
    logic [PHASE_BITS-1:0] r_acc;
    logic [PHASE_BITS-1:0] n_acc;
    logic signed [63:0]    step_ext;
    t_tag                  r_tag;
    t_tag                  n_tag;

    assign step_ext = 64'(signed'(r_step));

    always_comb begin
        n_acc = r_acc;
        n_tag = r_tag;
        if (i_accept) begin
            n_acc = r_acc + step_ext[PHASE_BITS-1:0];
        end
        if (i_adv) begin
            n_tag.valid = i_accept;
            n_tag.last  = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_acc       <= '0;
            r_tag.valid <= 1'b0;
        end else begin
            if (i_cfg_wvalid) begin
                r_step <= i_cfg_wdata;
            end
            r_acc       <= n_acc;
            r_tag.valid <= n_tag.valid;
        end
        r_tag.last <= n_tag.last;
    end

    assign o_phase = r_acc;
    assign o_tag   = r_tag;

endmodule

### design/qtnco_rom.sv
// ----------------------------------------------------------------------------
// qtnco_rom
// quarter-wave sine rom, two registered reads per cycle while the stage advances
// ----------------------------------------------------------------------------
module qtnco_rom #(
    parameter int PHASE_BITS      = qtnco_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = qtnco_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [PHASE_BITS-1:0]           i_phase,
    input  qtnco_pkg::t_tag                 i_tag,
    input  logic                            i_adv,
    output logic [qtnco_pkg::WORD_BITS-1:0] o_sin_a,
    output logic [qtnco_pkg::WORD_BITS-1:0] o_sin_b,
    output qtnco_pkg::t_rom_tag             o_tag
);
    import qtnco_pkg::*;

    localparam int N     = 1 << TABLE_ADDR_BITS;
    localparam int DEPTH = N + 1;
    localparam int TOP   = TABLE_ADDR_BITS + 2;

    typedef logic [WORD_BITS-1:0] t_rom [0:DEPTH-1];

    function automatic t_rom build_rom();
        t_rom r;
        for (int k = 0; k < DEPTH; k++) begin
            r[k] = sin_entry(k, TABLE_ADDR_BITS);
        end
        return r;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [TOP-1:0]             top;
    logic [TABLE_ADDR_BITS:0]   addr_a;
    logic [TABLE_ADDR_BITS:0]   addr_b;
    logic [WORD_BITS-1:0]       r_sin_a;
    logic [WORD_BITS-1:0]       r_sin_b;
    t_rom_tag                   r_tag;

    assign top    = i_phase[PHASE_BITS-1 -: TOP];
    assign addr_a = {1'b0, top[TABLE_ADDR_BITS-1:0]};
    // b = N - a, reaches N when a is zero
    assign addr_b = (TABLE_ADDR_BITS+1)'(N) - addr_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_adv) begin
            r_tag.valid <= i_tag.valid;
        end
        if (i_adv) begin
            r_sin_a    <= ROM[addr_a];
            r_sin_b    <= ROM[addr_b];
            r_tag.last <= i_tag.last;
            r_tag.quad <= t_quad'(top[TOP-1 -: 2]);
        end
    end

    assign o_sin_a = r_sin_a;
    assign o_sin_b = r_sin_b;
    assign o_tag   = r_tag;

endmodule

### design/qtnco_out.sv
// ----------------------------------------------------------------------------
// qtnco_out
// quadrant folding, marker bits and output register
// ----------------------------------------------------------------------------
module qtnco_out (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [qtnco_pkg::WORD_BITS-1:0] i_sin_a,
    input  logic [qtnco_pkg::WORD_BITS-1:0] i_sin_b,
    input  qtnco_pkg::t_rom_tag             i_tag,
    input  logic                            i_adv,
    output logic [qtnco_pkg::WORD_BITS-1:0] o_i_word,
    output logic [qtnco_pkg::WORD_BITS-1:0] o_q_word,
    output logic                            o_last,
    output logic                            o_valid
);
    import qtnco_pkg::*;

    logic [WORD_BITS-1:0] cos_v;
    logic [WORD_BITS-1:0] sin_v;
    logic [WORD_BITS-1:0] r_i_word;
    logic [WORD_BITS-1:0] r_q_word;
    logic                 r_last;
    logic                 r_valid;

    always_comb begin
        case (i_tag.quad)
            QUAD_0: begin
                cos_v = i_sin_b;
                sin_v = i_sin_a;
            end
            QUAD_1: begin
                cos_v = WORD_BITS'(0) - i_sin_a;
                sin_v = i_sin_b;
            end
            QUAD_2: begin
                cos_v = WORD_BITS'(0) - i_sin_b;
                sin_v = WORD_BITS'(0) - i_sin_a;
            end
            QUAD_3: begin
                cos_v = i_sin_a;
                sin_v = WORD_BITS'(0) - i_sin_b;
            end
            default: begin
                cos_v = i_sin_a;
                sin_v = i_sin_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_i_word <= I_MARK | cos_v;
            r_q_word <= Q_MARK | sin_v;
            r_last   <= i_tag.last;
        end
    end

    assign o_i_word = r_i_word;
    assign o_q_word = r_q_word;
    assign o_last   = r_last;
    assign o_valid  = r_valid;

endmodule

### design/quadrature_tone_nco_top.sv
// ----------------------------------------------------------------------------
// quadrature_tone_nco_top
// quadrature tone generator: phase accumulator, quarter-wave rom, I/Q words
// ----------------------------------------------------------------------------
// Each word taken on the slave stream (tdata bit 0 = end of buffer) advances
// the phase by the signed step and yields one I/Q word on the master stream:
// tdata[15:0] is the I word, tdata[31:16] the Q word, tlast copies the flag.
// The phase step is written on the cfg channel, which is always ready; write
// it only while no words are in flight.
// From accept to output valid a word passes the accumulator register, the
// registered dual-port rom read, then the quadrant fold into the output
// register. Throughput is one word per cycle while the receiver is ready;
// the rom's registered read sets the pipeline depth.
// Each stage holds its word only while the stage after it is full and
// stalled, so bubbles close up and the slave side keeps taking words until
// all three stages are full behind a stalled receiver.
// Reset clears the step, the phase and all valid bits; no rom clearing is
// needed since the table is constant.
// ----------------------------------------------------------------------------
module quadrature_tone_nco_top #(
    parameter int PHASE_BITS      = qtnco_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = qtnco_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // phase step write
    input  logic                                 i_cfg_wvalid,
    output logic                                 o_cfg_wready,
    input  logic [qtnco_pkg::STEP_BITS-1:0]      i_cfg_wdata,
    // slave stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [qtnco_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,  // [0] end_of_buffer
    // master stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [qtnco_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,  // [15:0] i_word, [31:16] q_word
    output logic                                 o_m_axis_tlast   // last_pair
);
    import qtnco_pkg::*;

    logic                  adv_out;
    logic                  adv_rom;
    logic                  adv_ph;
    logic                  accept;
    logic [PHASE_BITS-1:0] phase;
    t_tag                  ph_tag;
    t_rom_tag              rom_tag;
    logic [WORD_BITS-1:0]  sin_a;
    logic [WORD_BITS-1:0]  sin_b;
    logic [WORD_BITS-1:0]  i_word;
    logic [WORD_BITS-1:0]  q_word;
    logic                  out_valid;

    // a stage loads when it is empty or its word moves on
    assign adv_out = !out_valid || i_m_axis_tready;
    assign adv_rom = !rom_tag.valid || adv_out;
    assign adv_ph  = !ph_tag.valid || adv_rom;
    assign accept  = i_s_axis_tvalid && adv_ph;

    assign o_s_axis_tready = adv_ph;
    assign o_cfg_wready    = 1'b1;

    qtnco_phase #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wvalid (i_cfg_wvalid),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_last       (i_s_axis_tdata[0]),
        .i_adv        (adv_ph),
        .o_phase      (phase),
        .o_tag        (ph_tag)
    );

    qtnco_rom #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_phase (phase),
        .i_tag   (ph_tag),
        .i_adv   (adv_rom),
        .o_sin_a (sin_a),
        .o_sin_b (sin_b),
        .o_tag   (rom_tag)
    );

    qtnco_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sin_a  (sin_a),
        .i_sin_b  (sin_b),
        .i_tag    (rom_tag),
        .i_adv    (adv_out),
        .o_i_word (i_word),
        .o_q_word (q_word),
        .o_last   (o_m_axis_tlast),
        .o_valid  (out_valid)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {q_word, i_word};

endmodule
